// File: hdl/assert_macros.svh
// Assertion helpers for the RTL; abs_back.sv is the file that includes them.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the trigger holds, the consequence holds at the same edge.
`define ASSERT_IMPLIES(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// When the trigger holds, the consequence holds at the next edge.
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// File: hdl/abs_pkg.sv
package abs_pkg;

  // Action codes carried on the input channel.
  localparam logic [1:0] ACT_MESSAGE = 2'd0;
  localparam logic [1:0] ACT_ACK     = 2'd1;
  localparam logic [1:0] ACT_TICK    = 2'd2;

  localparam int unsigned TIMER_BITS = 16;
  localparam logic [TIMER_BITS-1:0] WAIT_TICKS_RESET = 16'd1000;

  // Command classes handed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_ACK  = 2'd2,
    CMD_TICK = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      ack_number;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'b01,
    PH_AWAIT = 2'b10
  } phase_t;

endpackage

// File: hdl/abs_in_if.sv
interface abs_in_if #(
  parameter int PAYLOAD_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [PAYLOAD_BITS-1:0] payload;
  logic                    ack_number;
  logic                    ack_corrupt;

  modport source (output valid, action, payload, ack_number, ack_corrupt, input ready);
  modport sink   (input valid, action, payload, ack_number, ack_corrupt, output ready);
endinterface

// File: hdl/abs_out_if.sv
interface abs_out_if #(
  parameter int PAYLOAD_BITS = 32,
  parameter int LEVEL_W      = 5
);
  logic                    valid;
  logic                    ready;
  logic                    send_valid;
  logic                    send_seq;
  logic [PAYLOAD_BITS-1:0] send_payload;
  logic                    resend;
  logic [LEVEL_W-1:0]      queue_level;
  logic                    overflow;
  logic                    awaiting_ack;

  modport source (output valid, send_valid, send_seq, send_payload, resend, queue_level,
                  overflow, awaiting_ack, input ready);
  modport sink   (input valid, send_valid, send_seq, send_payload, resend, queue_level,
                  overflow, awaiting_ack, output ready);
endinterface

// File: hdl/abs_ram.sv
module abs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the contents from before a write in the same cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/abs_front.sv
module abs_front
  import abs_pkg::*;
#(
  parameter int PAYLOAD_BITS = 32
) (
  abs_in_if.sink                  req,
  output logic                    cmd_valid,
  input  logic                    cmd_ready,
  output cmd_t                    cmd,
  output logic [PAYLOAD_BITS-1:0] cmd_payload
);

  assign cmd_valid   = req.valid;
  assign req.ready   = cmd_ready;
  assign cmd_payload = req.payload;

  // A corrupted acknowledgement is dropped here, so the back end never sees it.
  always_comb begin
    cmd.ack_number = req.ack_number;
    unique case (req.action)
      ACT_MESSAGE: cmd.kind = CMD_PUSH;
      ACT_ACK:     cmd.kind = req.ack_corrupt ? CMD_NONE : CMD_ACK;
      ACT_TICK:    cmd.kind = CMD_TICK;
      default:     cmd.kind = CMD_NONE;
    endcase
  end

endmodule

// File: hdl/abs_cmd_queue.sv
module abs_cmd_queue #(
  parameter int WIDTH = 35
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam logic [1:0] FULL = 2'd2;

  logic [WIDTH-1:0] slot [2];
  logic [1:0]       count;
  logic             wr_ptr;
  logic             rd_ptr;
  logic             push;
  logic             pop;

  assign in_ready  = (count != FULL);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

endmodule

// File: hdl/abs_back.sv
`include "assert_macros.svh"

module abs_back
  import abs_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  output logic                    cmd_ready,
  input  cmd_t                    cmd,
  input  logic [PAYLOAD_BITS-1:0] cmd_payload,
  input  logic [TIMER_BITS-1:0]   wait_ticks,
  abs_out_if.source               rsp
);

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [LEVEL_W-1:0] FULL_LEVEL = LEVEL_W'(QUEUE_DEPTH);
  localparam logic [LEVEL_W-1:0] ONE_LEVEL  = LEVEL_W'(1);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  phase_t                  phase, phase_next;
  logic                    seq, seq_next;
  logic [IDX_W-1:0]        head_idx, head_idx_next;
  logic [IDX_W-1:0]        tail_idx, tail_idx_next;
  logic [LEVEL_W-1:0]      held, held_next;
  logic [TIMER_BITS-1:0]   ticks_left, ticks_left_next;
  // The head and the entry behind it are kept in registers; the store feeds the third.
  logic [PAYLOAD_BITS-1:0] head_data, head_data_next;
  logic [PAYLOAD_BITS-1:0] second_data, second_data_next;
  logic                    byp_valid;
  logic [PAYLOAD_BITS-1:0] byp_data;
  logic [PAYLOAD_BITS-1:0] ram_rdata;
  logic [PAYLOAD_BITS-1:0] third_data;
  logic [IDX_W-1:0]        raddr;
  logic                    ram_we;
  logic                    exec;
  logic                    pop;
  logic                    send;
  logic                    resend;
  logic                    ovf;
  logic [PAYLOAD_BITS-1:0] send_pay;

  assign cmd_ready  = !rsp.valid || rsp.ready;
  assign exec       = cmd_valid && cmd_ready;
  assign third_data = byp_valid ? byp_data : ram_rdata;
  assign raddr      = wrap_inc(wrap_inc(head_idx_next));

  always_comb begin
    phase_next       = phase;
    seq_next         = seq;
    head_idx_next    = head_idx;
    tail_idx_next    = tail_idx;
    held_next        = held;
    ticks_left_next  = ticks_left;
    head_data_next   = head_data;
    second_data_next = second_data;
    ram_we           = 1'b0;
    pop              = 1'b0;
    send             = 1'b0;
    resend           = 1'b0;
    ovf              = 1'b0;
    send_pay         = '0;
    if (exec) begin
      unique case (cmd.kind)
        CMD_PUSH: begin
          if (held == FULL_LEVEL) begin
            ovf = 1'b1;
          end else begin
            ram_we        = 1'b1;
            tail_idx_next = wrap_inc(tail_idx);
            held_next     = held + ONE_LEVEL;
            if (held == '0) begin
              head_data_next = cmd_payload;
            end
            if (held == ONE_LEVEL) begin
              second_data_next = cmd_payload;
            end
            if (phase == PH_IDLE) begin
              send            = 1'b1;
              send_pay        = cmd_payload;
              ticks_left_next = wait_ticks;
              phase_next      = PH_AWAIT;
            end
          end
        end
        CMD_ACK: begin
          if ((phase == PH_AWAIT) && (cmd.ack_number == seq)) begin
            pop              = 1'b1;
            head_idx_next    = wrap_inc(head_idx);
            held_next        = held - ONE_LEVEL;
            seq_next         = ~seq;
            head_data_next   = second_data;
            second_data_next = third_data;
            if (held != ONE_LEVEL) begin
              send            = 1'b1;
              send_pay        = second_data;
              ticks_left_next = wait_ticks;
            end else begin
              phase_next = PH_IDLE;
            end
          end
        end
        CMD_TICK: begin
          if (phase == PH_AWAIT) begin
            if (ticks_left <= TIMER_BITS'(1)) begin
              send            = 1'b1;
              resend          = 1'b1;
              send_pay        = head_data;
              ticks_left_next = wait_ticks;
            end else begin
              ticks_left_next = ticks_left - 1'b1;
            end
          end
        end
        CMD_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  abs_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_idx),
    .wdata (cmd_payload),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      seq        <= 1'b0;
      head_idx   <= '0;
      tail_idx   <= '0;
      held       <= '0;
      ticks_left <= '0;
      byp_valid  <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      phase      <= phase_next;
      seq        <= seq_next;
      head_idx   <= head_idx_next;
      tail_idx   <= tail_idx_next;
      held       <= held_next;
      ticks_left <= ticks_left_next;
      // A write landing on the address being read is forwarded past the store.
      byp_valid  <= ram_we && (tail_idx == raddr);
      if (cmd_ready) begin
        rsp.valid <= exec;
      end
    end
  end

  always_ff @(posedge clk) begin
    head_data   <= head_data_next;
    second_data <= second_data_next;
    byp_data    <= cmd_payload;
    if (cmd_ready) begin
      rsp.send_valid   <= send;
      rsp.send_seq     <= send ? seq_next : 1'b0;
      rsp.send_payload <= send_pay;
      rsp.resend       <= resend;
      rsp.queue_level  <= held_next;
      rsp.overflow     <= ovf;
      rsp.awaiting_ack <= (phase_next == PH_AWAIT);
    end
  end

  `ASSERT_ALWAYS(a_level_bound, held <= FULL_LEVEL, "queue level beyond depth")
  `ASSERT_ALWAYS(a_await_held, (phase == PH_AWAIT) == (held != '0),
                 "awaiting state disagrees with queue level")
  `ASSERT_NEXT(a_pop_level, pop, held == $past(held) - ONE_LEVEL,
               "acknowledgement did not remove one message")
  `ASSERT_IMPLIES(a_resend_await, rsp.valid && rsp.resend, rsp.awaiting_ack,
                  "retransmission reported while idle")

endmodule

// File: hdl/alternating_bit_sender.sv
// Alternating-bit protocol sender.
// The req channel carries one event per beat: a message handle from the upper
// layer, an acknowledgement (sequence bit and corruption flag) or a timer tick.
// For every accepted req beat exactly one beat leaves on the rsp channel; it says
// whether a packet goes to the link, with which sequence bit and handle, whether
// it is a timeout retransmission, the queue level, overflow and the await status.
// The retransmit interval is written through cfg_we and cfg_wdata; the user must do this
// only while idle, and the block does not enforce it. Throughput is one event per cycle
// unless rsp stalls: a front end classifies events into a two-entry command queue and the
// back end settles one command per cycle against its message store, a RAM with one write
// port and one registered read port, whose read delay is hidden by keeping the two leading
// messages in registers. A req beat is held in the command queue, then the result register.
// When the receiver stalls rsp, the result register holds, the back end stops,
// and req stays ready until the command queue has filled.
// Reset is synchronous: it empties the message queue, clears the sequence bit,
// returns to idle and loads the interval of 1000 ticks. There is no clearing pass.
module alternating_bit_sender
  import abs_pkg::*;
#(
  parameter int QUEUE_DEPTH  = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  abs_in_if.sink                req,
  abs_out_if.source             rsp,
  input  logic                  cfg_we,
  input  logic [TIMER_BITS-1:0] cfg_wdata
);

  localparam int CMD_W = $bits(cmd_t) + PAYLOAD_BITS;

  // Retransmit interval, in ticks.
  logic [TIMER_BITS-1:0] wait_ticks;

  // Between the front end and the command queue.
  logic                    fe_valid;
  logic                    fe_ready;
  cmd_t                    fe_cmd;
  logic [PAYLOAD_BITS-1:0] fe_payload;

  // Between the command queue and the back end.
  logic                    be_valid;
  logic                    be_ready;
  logic [CMD_W-1:0]        be_data;
  cmd_t                    be_cmd;
  logic [PAYLOAD_BITS-1:0] be_payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_ticks <= WAIT_TICKS_RESET;
    end else if (cfg_we) begin
      wait_ticks <= cfg_wdata;
    end
  end

  abs_front #(
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .req         (req),
    .cmd_valid   (fe_valid),
    .cmd_ready   (fe_ready),
    .cmd         (fe_cmd),
    .cmd_payload (fe_payload)
  );

  // The queue lets the front end keep taking beats while the back end waits.
  abs_cmd_queue #(
    .WIDTH (CMD_W)
  ) u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fe_valid),
    .in_ready  (fe_ready),
    .in_data   ({fe_cmd, fe_payload}),
    .out_valid (be_valid),
    .out_ready (be_ready),
    .out_data  (be_data)
  );

  assign be_cmd     = cmd_t'(be_data[CMD_W-1:PAYLOAD_BITS]);
  assign be_payload = be_data[PAYLOAD_BITS-1:0];

  abs_back #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (be_valid),
    .cmd_ready   (be_ready),
    .cmd         (be_cmd),
    .cmd_payload (be_payload),
    .wait_ticks  (wait_ticks),
    .rsp         (rsp)
  );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench
  import abs_pkg::*;
  ();

  localparam int QDEPTH = 16;
  localparam int PAY_W = 32;
  localparam int LEVEL_W = 5;

  // The package names the three real actions. The fourth code does nothing, and the
  // block must still answer it with a status-only beat.
  localparam logic [1:0] ACT_NOTHING = 2'd3;

  // Settling time after the last response, before anything is written on the
  // configuration port.
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 300;

  // One response beat, held field by field so that each can be compared on its own.
  typedef struct {
    logic               send_valid;
    logic               send_seq;
    logic [PAY_W-1:0]   send_payload;
    logic               resend;
    logic [LEVEL_W-1:0] queue_level;
    logic               overflow;
    logic               awaiting_ack;
  } sender_beat_t;

  // Scoreboard for the sender. It carries its own copy of the protocol state: the
  // queue of message handles (the in-flight one at the front), the await flag, the
  // sequence bit, the retransmit countdown and the interval. Each accepted event
  // advances that state and leaves one expected response beat behind.
  class abp_scoreboard;
    bit               awaiting;
    bit               seq;
    bit [PAY_W-1:0]   held[$];
    bit [15:0]        ticks_left;
    bit [15:0]        wait_ticks;
    sender_beat_t     expected_q[$];
    int               errors;
    int               events;
    int               checked;
    int               sends;
    int               resends;
    int               drops;

    function new();
      awaiting = 1'b0;
      seq = 1'b0;
      held.delete();
      ticks_left = '0;
      wait_ticks = WAIT_TICKS_RESET;
    endfunction

    function void set_wait(bit [15:0] v);
      wait_ticks = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_event(logic [1:0] action, logic [PAY_W-1:0] payload,
                             logic ackn, logic corrupt);
      sender_beat_t want;
      bit send;
      bit again;
      bit drop;
      send = 1'b0;
      again = 1'b0;
      drop = 1'b0;
      events++;
      case (action)
        ACT_MESSAGE: begin
          if (held.size() >= QDEPTH) begin
            // A full queue drops the new message and changes nothing else.
            drop = 1'b1;
          end else begin
            held.push_back(payload);
            if (!awaiting) begin
              send = 1'b1;
              awaiting = 1'b1;
              ticks_left = wait_ticks;
            end
          end
        end
        ACT_ACK: begin
          // Only a clean acknowledgement of the in-flight bit moves the queue on.
          if (awaiting && !corrupt && ackn == seq && held.size() > 0) begin
            void'(held.pop_front());
            seq = ~seq;
            if (held.size() > 0) begin
              send = 1'b1;
              ticks_left = wait_ticks;
            end else begin
              awaiting = 1'b0;
            end
          end
        end
        ACT_TICK: begin
          if (awaiting) begin
            if (ticks_left <= 16'd1) begin
              send = 1'b1;
              again = 1'b1;
              ticks_left = wait_ticks;
            end else begin
              ticks_left = ticks_left - 16'd1;
            end
          end
        end
        default: begin
        end
      endcase
      want.send_valid = send;
      want.send_seq = send ? seq : 1'b0;
      want.send_payload = send ? held[0] : '0;
      want.resend = again;
      want.queue_level = LEVEL_W'(held.size());
      want.overflow = drop;
      want.awaiting_ack = awaiting;
      sends += send;
      resends += again;
      drops += drop;
      expected_q.push_back(want);
    endfunction

    // Prints one line per mismatch (up to a cap) and counts every one of them.
    task report(string what, logic [PAY_W-1:0] got, logic [PAY_W-1:0] want);
      errors++;
      if (errors <= 100)
        $display("mismatch at response %0d: %s is %0h, expected %0h", checked, what, got, want);
    endtask

    task check_beat(sender_beat_t got);
      sender_beat_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report("response with no event outstanding, send_payload", got.send_payload, '0);
      end else begin
        want = expected_q.pop_front();
        if (got.send_valid !== want.send_valid)
          report("send_valid", PAY_W'(got.send_valid), PAY_W'(want.send_valid));
        if (got.send_seq !== want.send_seq)
          report("send_seq", PAY_W'(got.send_seq), PAY_W'(want.send_seq));
        if (got.send_payload !== want.send_payload)
          report("send_payload", got.send_payload, want.send_payload);
        if (got.resend !== want.resend)
          report("resend", PAY_W'(got.resend), PAY_W'(want.resend));
        if (got.queue_level !== want.queue_level)
          report("queue_level", PAY_W'(got.queue_level), PAY_W'(want.queue_level));
        if (got.overflow !== want.overflow)
          report("overflow", PAY_W'(got.overflow), PAY_W'(want.overflow));
        if (got.awaiting_ack !== want.awaiting_ack)
          report("awaiting_ack", PAY_W'(got.awaiting_ack), PAY_W'(want.awaiting_ack));
      end
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_we;
  logic [TIMER_BITS-1:0] cfg_wdata;

  abs_in_if #(.PAYLOAD_BITS(PAY_W)) req_ch ();
  abs_out_if #(.PAYLOAD_BITS(PAY_W), .LEVEL_W(LEVEL_W)) rsp_ch ();

  abp_scoreboard sb = new;

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int send_idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  alternating_bit_sender #(
    .QUEUE_DEPTH (QDEPTH),
    .PAYLOAD_BITS(PAY_W)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a correct run finishes far below this, so reaching it means the block
  // has stopped answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d responses outstanding", cycle_count,
               sb.pending());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // The receiver stalls at random at the current rate. Ready is only ever changed
  // at the rising edge, so the block sees a settled value at the next one.
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Response monitor. The values read here are those from before this edge, which
  // are exactly the ones that the handshake was decided on.
  always @(posedge clk) begin
    sender_beat_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.send_valid = rsp_ch.send_valid;
      got.send_seq = rsp_ch.send_seq;
      got.send_payload = rsp_ch.send_payload;
      got.resend = rsp_ch.resend;
      got.queue_level = rsp_ch.queue_level;
      got.overflow = rsp_ch.overflow;
      got.awaiting_ack = rsp_ch.awaiting_ack;
      sb.check_beat(got);
    end
  end

  // Offers one event beat and returns at the edge where it is taken. Valid is left
  // high, so that back-to-back beats never lower and raise it in the same step; the
  // next call or the drain decides what it becomes.
  task automatic put_event(input logic [1:0] action, input logic [PAY_W-1:0] payload,
                           input logic ackn, input logic corrupt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= action;
    req_ch.payload <= payload;
    req_ch.ack_number <= ackn;
    req_ch.ack_corrupt <= corrupt;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_event(action, payload, ackn, corrupt);
  endtask

  // Stops offering events and waits until every response has come back, then lets
  // the pipeline settle so that the block is quiet before any register write.
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [TIMER_BITS-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_wait(v);
    @(posedge clk);
  endtask

  // One random event. Most of the traffic follows the protocol: acknowledgements
  // usually carry the bit in flight so that the queue really moves, and ticks are
  // frequent enough for short intervals to expire. The rest is corrupted or stale
  // acknowledgements and the do-nothing action.
  task automatic random_event(input int msg_pct);
    int pick;
    int ack_pct;
    logic [PAY_W-1:0] handle;
    logic ackn;
    logic corrupt;
    pick = $urandom_range(0, 99);
    ack_pct = (100 - msg_pct) * 55 / 100;
    case ($urandom_range(0, 15))
      0: handle = '0;
      1: handle = '1;
      default: handle = $urandom();
    endcase
    corrupt = ($urandom_range(0, 9) == 0);
    ackn = ($urandom_range(0, 9) < 8) ? sb.seq : ~sb.seq;
    if (pick < msg_pct)
      put_event(ACT_MESSAGE, handle, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else if (pick < msg_pct + ack_pct)
      put_event(ACT_ACK, $urandom(), ackn, corrupt);
    else if (pick < 97)
      put_event(ACT_TICK, $urandom(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    else
      put_event(ACT_NOTHING, handle, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic random_phase(input int msg_pct, input bit pause_midway);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      // Once in the run the sender holds off until the block has caught up fully.
      if (pause_midway && i == RANDOM_PER_PHASE / 2)
        drain_responses();
      random_event(msg_pct);
    end
  endtask

  initial begin
    req_ch.valid <= 1'b0;
    req_ch.action <= ACT_MESSAGE;
    req_ch.payload <= '0;
    req_ch.ack_number <= 1'b0;
    req_ch.ack_corrupt <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, at the reset interval and with neither side idling. Events
    // that arrive while nothing is in flight must be ignored, as must the unused
    // action code, a corrupted acknowledgement and one with the wrong bit.
    put_event(ACT_TICK, '0, 1'b0, 1'b0);
    put_event(ACT_ACK, '0, 1'b0, 1'b0);
    put_event(ACT_NOTHING, '1, 1'b1, 1'b1);
    put_event(ACT_MESSAGE, '0, 1'b0, 1'b0);
    put_event(ACT_TICK, '0, 1'b0, 1'b0);
    put_event(ACT_ACK, '0, 1'b0, 1'b1);
    put_event(ACT_ACK, '0, 1'b1, 1'b0);
    // The clean acknowledgement empties the queue and leaves the bit flipped, so the
    // next message goes out with bit one.
    put_event(ACT_ACK, '1, 1'b0, 1'b0);
    put_event(ACT_MESSAGE, '1, 1'b1, 1'b1);
    put_event(ACT_ACK, '0, 1'b1, 1'b0);
    drain_responses();

    // Smallest interval: every tick in flight is a retransmission. Then the queue is
    // filled to its depth and one more message is dropped.
    write_interval(16'd1);
    put_event(ACT_MESSAGE, 32'h5555_aaaa, 1'b0, 1'b0);
    put_event(ACT_TICK, '0, 1'b0, 1'b0);
    put_event(ACT_TICK, '1, 1'b1, 1'b1);
    for (int i = 0; i < QDEPTH; i++)
      put_event(ACT_MESSAGE, $urandom(), 1'b0, 1'b0);
    drain_responses();

    // Random phases, each with its own interval and its own mix of idling.
    write_interval(TIMER_BITS'($urandom_range(2, 6)));
    send_idle_pct = 0;
    stall_pct = 0;
    random_phase(45, 1'b0);
    drain_responses();

    // Largest interval: the timer never runs out here, so only acknowledgements
    // move the queue on.
    write_interval(16'hffff);
    send_idle_pct = 78;
    stall_pct = 0;
    random_phase(35, 1'b0);
    drain_responses();

    // Message-heavy traffic against a stalling receiver keeps the queue near full.
    write_interval(16'd1);
    send_idle_pct = 0;
    stall_pct = 78;
    random_phase(60, 1'b0);
    drain_responses();

    write_interval(TIMER_BITS'($urandom_range(3, 12)));
    send_idle_pct = 29;
    stall_pct = 29;
    random_phase(50, 1'b1);
    drain_responses();

    $display("testbench: %0d events, %0d responses checked", sb.events, sb.checked);
    $display("testbench: %0d packets sent, %0d of them retransmissions, %0d messages dropped",
             sb.sends, sb.resends, sb.drops);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/abs_pkg.sv
hdl/abs_in_if.sv
hdl/abs_out_if.sv
hdl/abs_ram.sv
hdl/abs_front.sv
hdl/abs_cmd_queue.sv
hdl/abs_back.sv
hdl/alternating_bit_sender.sv
bench/testbench.sv
